/* sv/swo_pkg.sv */
// ============================================================================
// swo_pkg
// Shared types, constants and fixed-point helpers for the steered wheel
// odometry integrator.
// ============================================================================
package swo_pkg;

  localparam int CORDIC_STEPS_DEF  = 16;
  localparam int POSITION_BITS_DEF = 32;
  localparam int ATAN_ENTRIES      = 24;
  localparam int CORDIC_W          = 36;
  localparam int MD_W              = 64;
  localparam int MD_MUL_BITS       = 34;
  localparam int MD_DIV_BITS       = 64;

  localparam logic [15:0] WHEEL_BASE_RST = 16'd21955;
  localparam logic [15:0] TIRE_SCALE_RST = 16'd9571;

  localparam logic signed [63:0] ONE_Q30        = 64'sd1073741824;
  localparam logic signed [63:0] GAIN_COMP_Q30  = 64'sd652032874;
  localparam logic signed [63:0] HALF_PI_Q32    = 64'sd6746518852;
  localparam logic signed [63:0] RAD_TO_BIN_Q16 = 64'sd683565276;
  localparam logic signed [63:0] DIST_DIVISOR   = 64'sd256000000;
  localparam logic signed [63:0] YAW_SCALE      = 64'sd31250;

  // distance divisor split as 2^14 * 15625; odd part by reciprocal 2^40 / 15625
  localparam logic signed [63:0] DIST_HALF  = DIST_DIVISOR >>> 1;
  localparam logic [39:0]        DIST_ODD   = 40'd15625;
  localparam logic signed [63:0] DIST_RECIP = 64'sd70368745;

  typedef enum logic {
    MD_MUL = 1'b0,
    MD_DIV = 1'b1
  } md_op_t;

  typedef struct packed {
    logic   start;
    md_op_t op;
  } md_ctl_t;

  localparam logic [0:0] REG_WHEEL_BASE = 1'b0;
  localparam logic [0:0] REG_TIRE_SCALE = 1'b1;

  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] r;
    case (idx)
      5'd0:  r = 30'd843314857;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043837;
      5'd3:  r = 30'd133525159;
      5'd4:  r = 30'd67021687;
      5'd5:  r = 30'd33543516;
      5'd6:  r = 30'd16775851;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194283;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048576;
      5'd11: r = 30'd524288;
      5'd12: r = 30'd262144;
      5'd13: r = 30'd131072;
      5'd14: r = 30'd65536;
      5'd15: r = 30'd32768;
      5'd16: r = 30'd16384;
      5'd17: r = 30'd8192;
      5'd18: r = 30'd4096;
      5'd19: r = 30'd2048;
      5'd20: r = 30'd1024;
      5'd21: r = 30'd512;
      5'd22: r = 30'd256;
      5'd23: r = 30'd128;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  // round to nearest, ties away from zero, divide by 2^k
  function automatic logic signed [63:0] rshr(input logic signed [63:0] v,
                                              input int unsigned k);
    logic [63:0] m;
    logic [63:0] q;
    m = v[63] ? 64'(-v) : 64'(v);
    q = (m + (64'd1 << (k - 1))) >> k;
    return v[63] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [63:0] sat64(input logic signed [63:0] v,
                                               input logic signed [63:0] lo,
                                               input logic signed [63:0] hi);
    logic signed [63:0] r;
    r = (v < lo) ? lo : ((v > hi) ? hi : v);
    return r;
  endfunction

endpackage

/* sv/swo_muldiv.sv */
// ============================================================================
// swo_muldiv
// Shared bit-serial signed multiplier and rounding divider. One bit per
// cycle; the divider rounds to nearest with ties away from zero.
// ============================================================================
module swo_muldiv (
  input  logic                     clk,
  input  logic                     rst_n,
  input  swo_pkg::md_ctl_t         ctl,
  input  logic signed [63:0]       a,
  input  logic signed [63:0]       b,
  output logic                     done,
  output logic signed [63:0]       res
);

  logic                                busy_r;
  logic                                fin_r;
  logic [5:0]                          cnt_r;
  swo_pkg::md_op_t                     op_r;
  logic                                neg_r;
  logic [63:0]                         acc_r;
  logic [63:0]                         am_r;
  logic [swo_pkg::MD_MUL_BITS-1:0]     mb_r;
  logic [31:0]                         rem_r;

  logic [63:0] a_mag;
  logic [63:0] b_mag;
  logic [32:0] rem2;
  logic [33:0] diff;
  logic        ge;

  assign a_mag = a[63] ? 64'(-a) : 64'(a);
  assign b_mag = b[63] ? 64'(-b) : 64'(b);
  assign rem2  = {rem_r, acc_r[63]};
  assign diff  = {1'b0, rem2} - {2'b00, am_r[31:0]};
  assign ge    = ~diff[33];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      fin_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= (ctl.op == swo_pkg::MD_MUL) ? 6'(swo_pkg::MD_MUL_BITS - 1)
                                              : 6'(swo_pkg::MD_DIV_BITS - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      op_r <= ctl.op;
      if (ctl.op == swo_pkg::MD_MUL) begin
        neg_r <= a[63] ^ b[63];
        acc_r <= '0;
        am_r  <= a_mag;
        mb_r  <= b_mag[swo_pkg::MD_MUL_BITS-1:0];
      end else begin
        neg_r <= a[63];
        acc_r <= a_mag + {33'd0, b[31:1]};
        am_r  <= {32'd0, b[31:0]};
        rem_r <= '0;
      end
    end else if (busy_r) begin
      if (op_r == swo_pkg::MD_MUL) begin
        if (mb_r[0]) begin
          acc_r <= acc_r + am_r;
        end
        am_r <= {am_r[62:0], 1'b0};
        mb_r <= mb_r >> 1;
      end else begin
        rem_r <= ge ? diff[31:0] : rem2[31:0];
        acc_r <= {acc_r[62:0], ge};
      end
    end
  end

  assign done = fin_r;
  assign res  = neg_r ? -$signed(acc_r) : $signed(acc_r);

endmodule

/* sv/steered_wheel_odometry_integrator.sv */
// ============================================================================
// steered_wheel_odometry_integrator
// Bicycle-model dead reckoning: integrates x, y and heading per update.
// ============================================================================
// Input channel (in_*): one beat per update with steering angle, wheel rate
// and elapsed time. Output channel (out_*): one beat per update with pose,
// yaw quaternion, speed and yaw rate. Configuration (cfg_*): write wheel_base
// (index 0) or tire_scale (index 1) while the block is idle.
// One update runs longer with nonzero steering and elapsed time than with zero
// steering; in_ready is low meanwhile. The duration is set by the bit-serial
// multiply/divide unit (up to 10 multiplies and 3 divides) and by the CORDIC
// passes (up to three passes).
// The result sits in an output register; the next update is accepted and
// computed while it waits, and the block holds in its final state until the
// receiver takes the pending beat.
// Reset clears pose and heading and loads the register reset values.
// ============================================================================
module steered_wheel_odometry_integrator #(
  parameter int CORDIC_STEPS  = swo_pkg::CORDIC_STEPS_DEF,
  parameter int POSITION_BITS = swo_pkg::POSITION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_steer_angle,
  input  logic signed [15:0] in_wheel_rate,
  input  logic [15:0]        in_elapsed_us,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic [15:0]        out_heading,
  output logic signed [15:0] out_quat_z,
  output logic signed [15:0] out_quat_w,
  output logic signed [15:0] out_speed,
  output logic signed [15:0] out_yaw_rate,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  localparam int NSTEPS = (CORDIC_STEPS > swo_pkg::ATAN_ENTRIES) ?
                          swo_pkg::ATAN_ENTRIES : CORDIC_STEPS;
  localparam int IW     = $clog2(NSTEPS);
  localparam int CW     = swo_pkg::CORDIC_W;
  localparam int PB     = POSITION_BITS;
  localparam logic signed [63:0] PMAX = (64'sd1 <<< (PB - 1)) - 64'sd1;
  localparam logic signed [63:0] PMIN = -PMAX - 64'sd1;

  typedef enum logic [19:0] {
    ST_IDLE = 20'h00001,
    ST_PROD = 20'h00002,
    ST_PDT  = 20'h00004,
    ST_DIST = 20'h00008,
    ST_DFIX = 20'h00010,
    ST_TANC = 20'h00020,
    ST_TAND = 20'h00040,
    ST_DRM  = 20'h00080,
    ST_DRD  = 20'h00100,
    ST_HEAD = 20'h00200,
    ST_ZMUL = 20'h00400,
    ST_ROT  = 20'h00800,
    ST_DXM  = 20'h01000,
    ST_DXA  = 20'h02000,
    ST_DYM  = 20'h04000,
    ST_DYA  = 20'h08000,
    ST_QUAT = 20'h10000,
    ST_YAWM = 20'h20000,
    ST_YAWD = 20'h40000,
    ST_DONE = 20'h80000
  } state_t;

  state_t state_r, state_nxt;

  logic [15:0]            wheel_base_r;
  logic [15:0]            tire_scale_r;
  logic signed [PB-1:0]   x_r;
  logic signed [PB-1:0]   y_r;
  logic [15:0]            head_r;

  logic signed [15:0]     sa_r;
  logic signed [15:0]     rate_r;
  logic [15:0]            dt_r;
  logic signed [32:0]     prod_r;
  logic signed [23:0]     dist_r;
  logic signed [63:0]     tmp_r;
  logic signed [63:0]     t_r;
  logic signed [63:0]     drad_r;
  logic signed [15:0]     speed_r;
  logic signed [15:0]     yaw_r;
  logic signed [15:0]     qz_r;
  logic signed [15:0]     qw_r;
  logic                   pass_r;
  logic                   issued_r;

  logic signed [CW-1:0]   cx_r, cy_r, cz_r;
  logic signed [CW-1:0]   cx_nxt, cy_nxt, cz_nxt;
  logic signed [CW-1:0]   c_r, s_r;
  logic [IW-1:0]          it_r;

  logic                   out_valid_r;
  logic signed [31:0]     opx_r, opy_r;
  logic [15:0]            ohead_r;
  logic signed [15:0]     oqz_r, oqw_r, ospd_r, oyaw_r;

  swo_pkg::md_ctl_t       md_ctl;
  logic signed [63:0]     md_a, md_b, md_res;
  logic                   md_done;
  logic                   is_md;

  logic signed [15:0]     sa_in;
  logic [31:0]            ang;
  logic [31:0]            ang_off;
  logic [1:0]             quad;
  logic [31:0]            ru;
  logic signed [CW-1:0]   atan_v;
  logic signed [CW-1:0]   dxs, dys;
  logic                   cdir;
  logic                   it_last;
  logic signed [63:0]     tan_den;
  logic [63:0]            wb;
  logic [63:0]            psum;
  logic signed [63:0]     xsum, ysum;
  logic                   out_free;
  logic [63:0]            dmag;
  logic [33:0]            dnum;
  logic [23:0]            dq0;
  logic [39:0]            dback;
  logic [23:0]            dq;

  assign sa_in = (in_steer_angle > 16'sd24576)  ?  16'sd24576 :
                 (in_steer_angle < -16'sd24576) ? -16'sd24576 : in_steer_angle;

  assign ang     = pass_r ? {1'b0, head_r, 15'd0} : {head_r, 16'd0};
  assign ang_off = ang + 32'h2000_0000;
  assign quad    = ang_off[31:30];
  assign ru      = ang - {quad, 30'd0};

  assign atan_v  = CW'(signed'({1'b0, swo_pkg::atan_q30(5'(it_r))}));
  assign dxs     = cy_r >>> it_r;
  assign dys     = cx_r >>> it_r;
  assign cdir    = ~cz_r[CW-1];
  assign cx_nxt  = cdir ? cx_r - dxs : cx_r + dxs;
  assign cy_nxt  = cdir ? cy_r + dys : cy_r - dys;
  assign cz_nxt  = cdir ? cz_r - atan_v : cz_r + atan_v;
  assign it_last = (it_r == IW'(NSTEPS - 1));

  assign tan_den = (cx_r < CW'(1)) ? 64'sd1 : 64'(cx_r);
  assign wb      = (wheel_base_r == 16'd0) ? 64'd1 : {48'd0, wheel_base_r};
  assign psum    = md_res + 64'h0000_0000_8000_0000;
  assign xsum    = 64'(x_r) + swo_pkg::rshr(md_res, 30);
  assign ysum    = 64'(y_r) + swo_pkg::rshr(md_res, 30);
  assign out_free = ~out_valid_r | out_ready;

  assign dmag  = (tmp_r[63] ? 64'(-tmp_r) : 64'(tmp_r)) + 64'(swo_pkg::DIST_HALF);
  assign dnum  = dmag[47:14];
  assign dq0   = md_res[63:40];
  assign dback = 40'(dq0) * swo_pkg::DIST_ODD;
  assign dq    = (dback > {6'd0, dnum}) ? dq0 - 24'd1 : dq0;

  always_comb begin
    md_a  = '0;
    md_b  = '0;
    is_md = 1'b1;
    md_ctl.op = swo_pkg::MD_MUL;
    case (state_r)
      ST_PROD: begin
        md_a = 64'(rate_r);
        md_b = {48'd0, tire_scale_r};
      end
      ST_PDT: begin
        md_a = 64'(prod_r);
        md_b = {48'd0, dt_r};
      end
      ST_DIST: begin
        md_a = {30'd0, dnum};
        md_b = swo_pkg::DIST_RECIP;
      end
      ST_TAND: begin
        md_ctl.op = swo_pkg::MD_DIV;
        md_a = 64'(cy_r) <<< 16;
        md_b = tan_den;
      end
      ST_DRM: begin
        md_a = t_r;
        md_b = 64'(dist_r);
      end
      ST_DRD: begin
        md_ctl.op = swo_pkg::MD_DIV;
        md_a = tmp_r;
        md_b = $signed(wb);
      end
      ST_HEAD: begin
        md_a = drad_r;
        md_b = swo_pkg::RAD_TO_BIN_Q16;
      end
      ST_ZMUL: begin
        md_a = 64'(signed'(ru));
        md_b = swo_pkg::HALF_PI_Q32;
      end
      ST_DXM: begin
        md_a = 64'(dist_r);
        md_b = 64'(c_r);
      end
      ST_DYM: begin
        md_a = 64'(dist_r);
        md_b = 64'(s_r);
      end
      ST_YAWM: begin
        md_a = drad_r;
        md_b = swo_pkg::YAW_SCALE;
      end
      ST_YAWD: begin
        md_ctl.op = swo_pkg::MD_DIV;
        md_a = tmp_r;
        md_b = {48'd0, dt_r};
      end
      default: is_md = 1'b0;
    endcase
    md_ctl.start = is_md & ~issued_r;
  end

  swo_muldiv u_md (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (md_ctl),
    .a     (md_a),
    .b     (md_b),
    .done  (md_done),
    .res   (md_res)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_PROD;
      ST_PROD: if (md_done) state_nxt = ST_PDT;
      ST_PDT:  if (md_done) state_nxt = ST_DIST;
      ST_DIST: if (md_done) state_nxt = ST_DFIX;
      ST_DFIX: state_nxt = (sa_r != 16'sd0) ? ST_TANC : ST_ZMUL;
      ST_TANC: if (it_last) state_nxt = ST_TAND;
      ST_TAND: if (md_done) state_nxt = ST_DRM;
      ST_DRM:  if (md_done) state_nxt = ST_DRD;
      ST_DRD:  if (md_done) state_nxt = ST_HEAD;
      ST_HEAD: if (md_done) state_nxt = ST_ZMUL;
      ST_ZMUL: if (md_done) state_nxt = ST_ROT;
      ST_ROT:  if (it_last) state_nxt = pass_r ? ST_QUAT : ST_DXM;
      ST_DXM:  if (md_done) state_nxt = ST_DXA;
      ST_DXA:  state_nxt = ST_DYM;
      ST_DYM:  if (md_done) state_nxt = ST_DYA;
      ST_DYA:  state_nxt = ST_ZMUL;
      ST_QUAT: state_nxt = (dt_r != 16'd0) ? ST_YAWM : ST_DONE;
      ST_YAWM: if (md_done) state_nxt = ST_YAWD;
      ST_YAWD: if (md_done) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      issued_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      wheel_base_r <= swo_pkg::WHEEL_BASE_RST;
      tire_scale_r <= swo_pkg::TIRE_SCALE_RST;
      x_r          <= '0;
      y_r          <= '0;
      head_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (md_ctl.start) begin
        issued_r <= 1'b1;
      end else if (md_done) begin
        issued_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          swo_pkg::REG_WHEEL_BASE: wheel_base_r <= cfg_wdata;
          swo_pkg::REG_TIRE_SCALE: tire_scale_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == ST_HEAD && md_done) begin
        head_r <= head_r + psum[47:32];
      end
      if (state_r == ST_DXA) begin
        x_r <= PB'(swo_pkg::sat64(xsum, PMIN, PMAX));
      end
      if (state_r == ST_DYA) begin
        y_r <= PB'(swo_pkg::sat64(ysum, PMIN, PMAX));
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        sa_r   <= sa_in;
        rate_r <= in_wheel_rate;
        dt_r   <= in_elapsed_us;
        pass_r <= 1'b0;
      end
      ST_PROD: if (md_done) begin
        prod_r  <= md_res[32:0];
        speed_r <= 16'(swo_pkg::sat64(swo_pkg::rshr(md_res, 16), -64'sd32768, 64'sd32767));
      end
      ST_PDT: if (md_done) tmp_r <= md_res;
      ST_DFIX: begin
        dist_r <= tmp_r[63] ? 24'(-dq) : dq;
        drad_r <= '0;
        cx_r   <= CW'(swo_pkg::ONE_Q30);
        cy_r   <= '0;
        cz_r   <= CW'(64'(sa_r) <<< 16);
        it_r   <= '0;
      end
      ST_TANC, ST_ROT: begin
        cx_r <= cx_nxt;
        cy_r <= cy_nxt;
        cz_r <= cz_nxt;
        it_r <= it_r + IW'(1);
        if (state_r == ST_ROT && it_last) begin
          case (quad)
            2'd0: begin c_r <= cx_nxt;  s_r <= cy_nxt;  end
            2'd1: begin c_r <= -cy_nxt; s_r <= cx_nxt;  end
            2'd2: begin c_r <= -cx_nxt; s_r <= -cy_nxt; end
            default: begin c_r <= cy_nxt; s_r <= -cx_nxt; end
          endcase
        end
      end
      ST_TAND: if (md_done) t_r <= md_res;
      ST_DRM: if (md_done) tmp_r <= md_res;
      ST_DRD: if (md_done) drad_r <= md_res;
      ST_ZMUL: if (md_done) begin
        cx_r <= CW'(swo_pkg::GAIN_COMP_Q30);
        cy_r <= '0;
        cz_r <= CW'(swo_pkg::rshr(md_res, 32));
        it_r <= '0;
      end
      ST_DYA: pass_r <= 1'b1;
      ST_QUAT: begin
        qz_r  <= 16'(swo_pkg::sat64(swo_pkg::rshr(64'(s_r), 16), -64'sd16384, 64'sd16384));
        qw_r  <= 16'(swo_pkg::sat64(swo_pkg::rshr(64'(c_r), 16), -64'sd16384, 64'sd16384));
        yaw_r <= '0;
      end
      ST_YAWM: if (md_done) tmp_r <= md_res;
      ST_YAWD: if (md_done) begin
        yaw_r <= 16'(swo_pkg::sat64(md_res, -64'sd32768, 64'sd32767));
      end
      ST_DONE: if (out_free) begin
        opx_r   <= 32'(swo_pkg::sat64(64'(x_r), -64'sd2147483648, 64'sd2147483647));
        opy_r   <= 32'(swo_pkg::sat64(64'(y_r), -64'sd2147483648, 64'sd2147483647));
        ohead_r <= head_r;
        oqz_r   <= qz_r;
        oqw_r   <= qw_r;
        ospd_r  <= speed_r;
        oyaw_r  <= yaw_r;
      end
      default: ;
    endcase
  end

  assign in_ready     = (state_r == ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_pos_x    = opx_r;
  assign out_pos_y    = opy_r;
  assign out_heading  = ohead_r;
  assign out_quat_z   = oqz_r;
  assign out_quat_w   = oqw_r;
  assign out_speed    = ospd_r;
  assign out_yaw_rate = oyaw_r;

endmodule

/* verif/tb_steered_wheel_odometry_integrator.sv */
// ============================================================================
// Steered wheel odometry integrator testbench
// Drives update beats with random idling on both channels, rebuilds the
// expected pose, quaternion, speed and yaw rate in a local fixed-point
// model of the integrator, and compares each result beat field by field.
// ============================================================================
module tb_steered_wheel_odometry_integrator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS = 16;
  localparam int PBITS = 32;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam longint ATAN_TAB [24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149,
    1048576, 524288, 262144, 131072, 65536, 32768,
    16384, 8192, 4096, 2048, 1024, 512, 256, 128};

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] speed;
    logic signed [15:0] yaw_rate;
  } pose_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_steer_angle = '0;
  logic signed [15:0] in_wheel_rate = '0;
  logic [15:0] in_elapsed_us = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_pos_x, out_pos_y;
  logic [15:0] out_heading;
  logic signed [15:0] out_quat_z, out_quat_w, out_speed, out_yaw_rate;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = swo_pkg::REG_WHEEL_BASE;
  logic [15:0] cfg_wdata = '0;

  steered_wheel_odometry_integrator u_top (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  logic [15:0] wheel_base_q, tire_scale_q;
  longint x_acc, y_acc;
  logic [15:0] heading_acc;
  pose_t pose_q[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 1'b0;
  int quiet_cycles = 0;

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint div_round(longint n, longint d);
    longint m, q;
    m = n < 0 ? -n : n;
    q = (m + d / 2) / d;
    return n < 0 ? -q : q;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic rotate(input longint x0, input longint z0, output longint xo,
                        output longint yo);
    longint x, y, z, dx, dy;
    x = x0;
    y = 0;
    z = z0;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end
    end
    xo = x;
    yo = y;
  endtask

  task automatic sin_cos(input logic [31:0] a, output longint c, output longint s);
    logic [1:0] q;
    logic [31:0] ru;
    longint r, z, cx, sy;
    q = 2'((a + 32'h2000_0000) >> 30);
    ru = a - {q, 30'd0};
    r = longint'($signed(ru));
    z = div_round(r * 64'sd6746518852, 64'sd4294967296);
    rotate(652032874, z, cx, sy);
    case (q)
      2'd0: begin c = cx;  s = sy;  end
      2'd1: begin c = -sy; s = cx;  end
      2'd2: begin c = -cx; s = -sy; end
      default: begin c = sy; s = -cx; end
    endcase
  endtask

  task automatic predict_pose(input logic signed [15:0] ang,
                              input logic signed [15:0] rate,
                              input logic [15:0] dt);
    longint pmax, pmin, sa, prod, dist_q, drad, yaw, c, s, hc, hs, cx, cy, t, w;
    logic [63:0] p;
    pose_t e;
    pmax = (longint'(1) << (PBITS - 1)) - 1;
    pmin = -pmax - 1;
    sa = clamp(longint'(ang), -24576, 24576);
    prod = longint'(rate) * longint'(tire_scale_q);
    dist_q = div_round(prod * longint'(dt), 256000000);
    drad = 0;
    yaw = 0;
    if (sa != 0) begin
      w = wheel_base_q != 0 ? longint'(wheel_base_q) : 1;
      rotate(1073741824, sa * 65536, cx, cy);
      if (cx < 1) cx = 1;
      t = div_round(cy * 65536, cx);
      drad = div_round(dist_q * t, w);
    end
    p = 64'(drad) * 64'd683565276;
    heading_acc = heading_acc + 16'((p + 64'h8000_0000) >> 32);
    sin_cos({heading_acc, 16'd0}, c, s);
    x_acc = clamp(x_acc + div_round(dist_q * c, 1073741824), pmin, pmax);
    y_acc = clamp(y_acc + div_round(dist_q * s, 1073741824), pmin, pmax);
    sin_cos({1'b0, heading_acc, 15'd0}, hc, hs);
    if (dt != 0) yaw = clamp(div_round(drad * 31250, longint'(dt)), -32768, 32767);
    e.pos_x = 32'(clamp(x_acc, -64'sd2147483648, 64'sd2147483647));
    e.pos_y = 32'(clamp(y_acc, -64'sd2147483648, 64'sd2147483647));
    e.heading = heading_acc;
    e.quat_z = 16'(clamp(div_round(hs, 65536), -16384, 16384));
    e.quat_w = 16'(clamp(div_round(hc, 65536), -16384, 16384));
    e.speed = 16'(clamp(div_round(prod, 65536), -32768, 32767));
    e.yaw_rate = 16'(yaw);
    pose_q.push_back(e);
  endtask

  task automatic send_update(input logic signed [15:0] ang,
                             input logic signed [15:0] rate,
                             input logic [15:0] dt);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid <= 1'b1;
    in_steer_angle <= ang;
    in_wheel_rate <= rate;
    in_elapsed_us <= dt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pose(ang, rate, dt);
    @(negedge clk);
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (pose_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == swo_pkg::REG_WHEEL_BASE) wheel_base_q = val;
    else tire_scale_q = val;
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(9))
      0: return 16'($urandom);
      1: return 16'sd0;
      2: return 16'($urandom_range(49152) - 24576) & 16'hFFC0;
      default: return 16'($urandom_range(49152) - 24576);
    endcase
  endfunction

  function automatic logic [15:0] rand_dt();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'($urandom);
      default: return 16'($urandom_range(20000, 5000));
    endcase
  endfunction

  task automatic test_directed();
    logic signed [15:0] angs [7] = '{0, 1, -1, 24576, -24576, 16'sh7FFF, 16'sh8000};
    foreach (angs[i]) send_update(angs[i], 16'sd4096, 16'd10000);
    send_update(16'sd8000, 16'sh7FFF, 16'hFFFF);
    send_update(-16'sd8000, 16'sh8000, 16'hFFFF);
    send_update(16'sd3000, 16'sd2000, 16'd0);
    send_update(16'sd0, 16'sd0, 16'd0);
    send_update(16'sd24576, 16'sh7FFF, 16'hFFFF);
    send_update(-16'sd24576, 16'sh7FFF, 16'hFFFF);
    drain();
    write_reg(swo_pkg::REG_WHEEL_BASE, 16'd0);
    write_reg(swo_pkg::REG_TIRE_SCALE, 16'hFFFF);
    send_update(16'sd24576, 16'sh7FFF, 16'hFFFF);
    send_update(16'sd100, 16'sh8000, 16'hFFFF);
    send_update(16'sd0, 16'sh7FFF, 16'hFFFF);
    drain();
    write_reg(swo_pkg::REG_TIRE_SCALE, 16'd0);
    send_update(16'sd5000, 16'sh7FFF, 16'd3000);
    drain();
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++)
      send_update(rand_angle(), 16'($urandom), rand_dt());
  endtask

  task automatic test_saturation();
    write_reg(swo_pkg::REG_WHEEL_BASE, 16'd1);
    write_reg(swo_pkg::REG_TIRE_SCALE, 16'hFFFF);
    for (int i = 0; i < 60; i++)
      send_update(16'($urandom_range(200) - 100), 16'sh7FFF, 16'hFFFF);
    for (int i = 0; i < 60; i++)
      send_update(16'sd0, 16'sh8000, 16'hFFFF);
    drain();
  endtask

  task automatic test_backpressure();
    fork
      begin
        recv_hold = 1'b1;
        repeat (3000) @(negedge clk);
        recv_hold = 1'b0;
      end
      test_random(8);
    join
    drain();
  endtask

  initial begin
    wheel_base_q = swo_pkg::WHEEL_BASE_RST;
    tire_scale_q = swo_pkg::TIRE_SCALE_RST;
    x_acc = 0;
    y_acc = 0;
    heading_acc = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    send_idle_pct = 10;
    recv_idle_pct = 87;
    write_reg(swo_pkg::REG_WHEEL_BASE, 16'hFFFF);
    write_reg(swo_pkg::REG_TIRE_SCALE, 16'd30000);
    test_random(550);
    drain();
    send_idle_pct = 87;
    recv_idle_pct = 10;
    write_reg(swo_pkg::REG_WHEEL_BASE, 16'd21955);
    write_reg(swo_pkg::REG_TIRE_SCALE, 16'd9571);
    test_random(550);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    write_reg(swo_pkg::REG_WHEEL_BASE, 16'd300);
    write_reg(swo_pkg::REG_TIRE_SCALE, 16'($urandom));
    test_random(600);
    drain();
    test_saturation();
    if (mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(negedge clk)
    out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    pose_t got, e;
    if (out_valid && out_ready) begin
      got = '{out_pos_x, out_pos_y, out_heading, out_quat_z, out_quat_w, out_speed,
              out_yaw_rate};
      if (pose_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        e = pose_q.pop_front();
        if (got !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", e, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end
endmodule
